@@ hw/rtl/bmi_pkg.sv @@
// Shared types and constants for the binary modular inverse unit.
package bmi_pkg;

  localparam int LIMBS_DEF = 4;
  localparam int LIMB_W    = 64;
  localparam int VEC_W     = 3;

  // vectors held in the limb memory
  typedef enum logic [VEC_W-1:0] {
    VEC_A, VEC_M, VEC_U, VEC_V, VEC_X1, VEC_X2, VEC_T
  } vec_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_MOV, OP_CLR, OP_ONE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_EVEN, ST_NOINV, ST_LONG
  } status_t;

  typedef struct packed {
    logic start;
    op_t  op;
    vec_t src_a;
    vec_t src_b;
    vec_t dst;
    logic wen;
    logic cin_carry;
  } op_cmd_t;

  typedef struct packed {
    logic done;
    logic carry;
    logic zero;
    logic one;
    logic lsb;
  } op_flags_t;

  typedef enum logic [5:0] {
    S_CLRA, S_CLRM, S_IDLE, S_LDM, S_CHECK,
    S_RCLR, S_R1, S_R2, S_R3, S_R4, S_RDEC,
    S_INITV, S_INITX1, S_INITX2,
    S_TU, S_TV, S_EU, S_SHU, S_EV, S_SHV,
    S_H0, S_HADD, S_HSHRC, S_HSHR0, S_HSUB, S_HMOV,
    S_CMP, S_CMPU, S_CMPV,
    S_SM0, S_SMADD, S_SMSUB, S_SMMOV,
    S_FIN, S_FCOPY, S_FSUB, S_FMOV,
    S_OUTRD, S_OUTLD, S_OUTHOLD
  } seq_state_t;

endpackage

@@ hw/rtl/bmi_mem.sv @@
// Limb memory: one write port, two registered read ports.
module bmi_mem
  import bmi_pkg::*;
#(
  parameter int AW = VEC_W + 2,
  parameter int DW = LIMB_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/bmi_alu.sv @@
// Limb-serial arithmetic engine working on vectors in the limb memory.
module bmi_alu
  import bmi_pkg::*;
#(
  parameter int LIMBS = LIMBS_DEF,
  parameter int LW    = (LIMBS > 1) ? $clog2(LIMBS) : 1,
  parameter int AW    = VEC_W + LW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  op_cmd_t           cmd,
  output op_flags_t         flags,
  input  logic              ext_we,
  input  logic [AW-1:0]     ext_waddr,
  input  logic [LIMB_W-1:0] ext_wdata,
  input  logic [AW-1:0]     ext_raddr,
  output logic [LIMB_W-1:0] ext_rdata
);

  localparam int SW = $clog2(LIMBS + 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(LIMBS);
  localparam logic [LW-1:0] TOP_IDX   = LW'(LIMBS - 1);

  op_cmd_t           cmd_r;
  logic              busy_r;
  logic [SW-1:0]     step_r;
  logic              pvalid_r;
  logic [LW-1:0]     pidx_r;
  logic              carry_r;
  logic              zero_r;
  logic              one_r;
  logic              lsb_r;
  logic              done_r;

  logic [LW-1:0]     ridx;
  logic              issue;
  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LIMB_W-1:0] mem_wdata;
  logic [LIMB_W-1:0] rd_a;
  logic [LIMB_W-1:0] rd_b;
  logic [LIMB_W-1:0] res;
  logic              cout;
  logic [LIMB_W:0]   sum;

  // right shifts walk from the top limb down
  assign ridx  = (cmd_r.op == OP_SHR) ? (TOP_IDX - step_r[LW-1:0]) : step_r[LW-1:0];
  assign issue = busy_r && (step_r < LAST_STEP);

  assign raddr_a   = busy_r ? {cmd_r.src_a, ridx} : ext_raddr;
  assign raddr_b   = {cmd_r.src_b, ridx};
  assign mem_we    = busy_r ? (pvalid_r && cmd_r.wen) : ext_we;
  assign mem_waddr = busy_r ? {cmd_r.dst, pidx_r} : ext_waddr;
  assign mem_wdata = busy_r ? res : ext_wdata;
  assign ext_rdata = rd_a;

  bmi_mem #(.AW(AW), .DW(LIMB_W)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    sum  = '0;
    res  = rd_a;
    cout = carry_r;
    case (cmd_r.op)
      OP_ADD: begin
        sum  = {1'b0, rd_a} + {1'b0, rd_b} + {{LIMB_W{1'b0}}, carry_r};
        res  = sum[LIMB_W-1:0];
        cout = sum[LIMB_W];
      end
      OP_SUB: begin
        // bit LIMB_W of the difference is the borrow
        sum  = {1'b0, rd_a} - {1'b0, rd_b} - {{LIMB_W{1'b0}}, carry_r};
        res  = sum[LIMB_W-1:0];
        cout = sum[LIMB_W];
      end
      OP_SHL: begin
        res  = {rd_a[LIMB_W-2:0], carry_r};
        cout = rd_a[LIMB_W-1];
      end
      OP_SHR: begin
        res  = {carry_r, rd_a[LIMB_W-1:1]};
        cout = rd_a[0];
      end
      OP_MOV: res = rd_a;
      OP_CLR: res = '0;
      OP_ONE: res = (pidx_r == '0) ? LIMB_W'(1) : '0;
      default: res = rd_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pvalid_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
      carry_r  <= 1'b0;
    end else begin
      pvalid_r <= issue;
      pidx_r   <= ridx;
      done_r   <= busy_r && (step_r == LAST_STEP);
      if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end else if (cmd.start) begin
        busy_r  <= 1'b1;
        step_r  <= '0;
        cmd_r   <= cmd;
        carry_r <= cmd.cin_carry ? carry_r : 1'b0;
        zero_r  <= 1'b1;
        one_r   <= 1'b1;
      end
      if (busy_r && pvalid_r) begin
        carry_r <= cout;
        zero_r  <= zero_r && (rd_a == '0);
        one_r   <= one_r && ((pidx_r == '0) ? (rd_a == LIMB_W'(1)) : (rd_a == '0));
        if (pidx_r == '0) begin
          lsb_r <= rd_a[0];
        end
      end
    end
  end

  assign flags = '{done: done_r, carry: carry_r, zero: zero_r, one: one_r, lsb: lsb_r};

endmodule

@@ hw/rtl/bmi_seq.sv @@
// Sequencer: limb loading, inversion microcode and result streaming.
module bmi_seq
  import bmi_pkg::*;
#(
  parameter int LIMBS = LIMBS_DEF,
  parameter int LW    = (LIMBS > 1) ? $clog2(LIMBS) : 1,
  parameter int AW    = VEC_W + LW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LIMB_W-1:0] in_operand_limb,
  input  logic [LIMB_W-1:0] in_modulus_limb,
  input  logic              in_final_limb,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LIMB_W-1:0] out_result_limb,
  output logic [1:0]        out_status,
  output logic              out_last_result,
  output op_cmd_t           cmd,
  input  op_flags_t         flags,
  output logic              ext_we,
  output logic [AW-1:0]     ext_waddr,
  output logic [LIMB_W-1:0] ext_wdata,
  output logic [AW-1:0]     ext_raddr,
  input  logic [LIMB_W-1:0] ext_rdata
);

  localparam int SW = $clog2(LIMBS + 1);
  localparam int BW = $clog2(LIMBS * LIMB_W + 1);
  localparam logic [SW-1:0] LIMBS_CNT = SW'(LIMBS);
  localparam logic [BW-1:0] BITS      = BW'(LIMBS * LIMB_W);
  localparam logic [LW-1:0] TOP_IDX   = LW'(LIMBS - 1);

  seq_state_t        state_r, state_nxt;
  logic              issued_r;
  logic [SW-1:0]     lc_r;
  logic              long_r;
  logic              mlsb_r;
  logic [LIMB_W-1:0] mod_hold_r;
  logic              final_r;
  status_t           status_r;
  logic [BW-1:0]     bitcnt_r;
  logic              out_bit_r;
  logic              u_one_r;
  logic              u_zero_r;
  logic              which_r;
  logic [LW-1:0]     k_r;
  logic              out_valid_r;
  logic [LIMB_W-1:0] out_limb_r;
  logic              out_last_r;

  logic              is_op;
  logic              done;
  logic              room;
  vec_t              xv;
  vec_t              yv;

  assign done = flags.done && issued_r;
  assign room = (lc_r < LIMBS_CNT);
  // which_r picks the coefficient: X1 for the u side, X2 for the v side
  assign xv   = which_r ? VEC_X2 : VEC_X1;
  assign yv   = which_r ? VEC_X1 : VEC_X2;

  // op issue and memory side port
  always_comb begin
    is_op     = 1'b1;
    cmd       = '0;
    cmd.op    = OP_MOV;
    cmd.wen   = 1'b1;
    in_ready  = 1'b0;
    ext_we    = 1'b0;
    ext_waddr = {VEC_A, lc_r[LW-1:0]};
    ext_wdata = in_operand_limb;
    ext_raddr = {VEC_X1, k_r};
    case (state_r)
      S_CLRA:   begin cmd.op = OP_CLR; cmd.dst = VEC_A; end
      S_CLRM:   begin cmd.op = OP_CLR; cmd.dst = VEC_M; end
      S_RCLR:   begin cmd.op = OP_CLR; cmd.dst = VEC_U; end
      S_R1:     begin cmd.op = OP_SHL; cmd.src_a = VEC_A; cmd.dst = VEC_A; end
      S_R2: begin
        cmd.op = OP_SHL; cmd.src_a = VEC_U; cmd.dst = VEC_U; cmd.cin_carry = 1'b1;
      end
      S_R3: begin
        cmd.op = OP_SUB; cmd.src_a = VEC_U; cmd.src_b = VEC_M; cmd.dst = VEC_T;
      end
      S_R4:     begin cmd.src_a = VEC_T; cmd.dst = VEC_U; end
      S_INITV:  begin cmd.src_a = VEC_M; cmd.dst = VEC_V; end
      S_INITX1: begin cmd.op = OP_ONE; cmd.dst = VEC_X1; end
      S_INITX2: begin cmd.op = OP_CLR; cmd.dst = VEC_X2; end
      S_TU, S_EU: begin cmd.src_a = VEC_U; cmd.wen = 1'b0; end
      S_TV, S_EV: begin cmd.src_a = VEC_V; cmd.wen = 1'b0; end
      S_SHU:    begin cmd.op = OP_SHR; cmd.src_a = VEC_U; cmd.dst = VEC_U; end
      S_SHV:    begin cmd.op = OP_SHR; cmd.src_a = VEC_V; cmd.dst = VEC_V; end
      S_H0:     begin cmd.src_a = xv; cmd.wen = 1'b0; end
      S_HADD, S_SMADD: begin
        cmd.op = OP_ADD; cmd.src_a = xv; cmd.src_b = VEC_M; cmd.dst = xv;
      end
      S_HSHRC: begin
        cmd.op = OP_SHR; cmd.src_a = xv; cmd.dst = xv; cmd.cin_carry = 1'b1;
      end
      S_HSHR0:  begin cmd.op = OP_SHR; cmd.src_a = xv; cmd.dst = xv; end
      S_HSUB, S_SMSUB: begin
        cmd.op = OP_SUB; cmd.src_a = xv; cmd.src_b = VEC_M; cmd.dst = VEC_T;
      end
      S_HMOV, S_SMMOV: begin cmd.src_a = VEC_T; cmd.dst = xv; end
      S_CMP: begin
        cmd.op = OP_SUB; cmd.src_a = VEC_U; cmd.src_b = VEC_V; cmd.dst = VEC_T;
      end
      S_CMPU:   begin cmd.src_a = VEC_T; cmd.dst = VEC_U; end
      S_CMPV: begin
        cmd.op = OP_SUB; cmd.src_a = VEC_V; cmd.src_b = VEC_U; cmd.dst = VEC_V;
      end
      S_SM0:    begin cmd.op = OP_SUB; cmd.src_a = xv; cmd.src_b = yv; cmd.dst = xv; end
      S_FCOPY:  begin cmd.src_a = VEC_X2; cmd.dst = VEC_X1; end
      S_FSUB: begin
        cmd.op = OP_SUB; cmd.src_a = VEC_X1; cmd.src_b = VEC_M; cmd.dst = VEC_T;
      end
      S_FMOV:   begin cmd.src_a = VEC_T; cmd.dst = VEC_X1; end
      S_IDLE: begin
        is_op    = 1'b0;
        in_ready = 1'b1;
        ext_we   = in_valid && room;
      end
      S_LDM: begin
        is_op     = 1'b0;
        ext_we    = room;
        ext_waddr = {VEC_M, lc_r[LW-1:0]};
        ext_wdata = mod_hold_r;
      end
      default: is_op = 1'b0;
    endcase
    cmd.start = is_op && !issued_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLRA:   if (done) state_nxt = S_CLRM;
      S_CLRM:   if (done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_LDM;
      S_LDM:    state_nxt = final_r ? S_CHECK : S_IDLE;
      S_CHECK:  state_nxt = (long_r || !mlsb_r) ? S_OUTRD : S_RCLR;
      S_RCLR:   if (done) state_nxt = S_R1;
      S_R1:     if (done) state_nxt = S_R2;
      S_R2:     if (done) state_nxt = S_R3;
      S_R3:     if (done) state_nxt = (out_bit_r || !flags.carry) ? S_R4 : S_RDEC;
      S_R4:     if (done) state_nxt = S_RDEC;
      S_RDEC:   state_nxt = (bitcnt_r == BW'(1)) ? S_INITV : S_R1;
      S_INITV:  if (done) state_nxt = S_INITX1;
      S_INITX1: if (done) state_nxt = S_INITX2;
      S_INITX2: if (done) state_nxt = S_TU;
      S_TU:     if (done) state_nxt = S_TV;
      S_TV: begin
        if (done) begin
          if (u_one_r || flags.one) begin
            state_nxt = S_FIN;
          end else if (u_zero_r || flags.zero) begin
            state_nxt = S_OUTRD;
          end else begin
            state_nxt = S_EU;
          end
        end
      end
      S_EU:     if (done) state_nxt = flags.lsb ? S_EV : S_SHU;
      S_SHU:    if (done) state_nxt = S_H0;
      S_EV:     if (done) state_nxt = flags.lsb ? S_CMP : S_SHV;
      S_SHV:    if (done) state_nxt = S_H0;
      S_H0:     if (done) state_nxt = flags.lsb ? S_HADD : S_HSHR0;
      S_HADD:   if (done) state_nxt = S_HSHRC;
      S_HSHRC:  if (done) state_nxt = S_HSUB;
      S_HSHR0:  if (done) state_nxt = S_HSUB;
      S_HSUB: begin
        if (done) begin
          if (!flags.carry) begin
            state_nxt = S_HMOV;
          end else begin
            state_nxt = which_r ? S_EV : S_EU;
          end
        end
      end
      S_HMOV:   if (done) state_nxt = which_r ? S_EV : S_EU;
      S_CMP:    if (done) state_nxt = flags.carry ? S_CMPV : S_CMPU;
      S_CMPU:   if (done) state_nxt = S_SM0;
      S_CMPV:   if (done) state_nxt = S_SM0;
      S_SM0:    if (done) state_nxt = flags.carry ? S_SMADD : S_SMSUB;
      S_SMADD:  if (done) state_nxt = S_SMSUB;
      S_SMSUB:  if (done) state_nxt = flags.carry ? S_TU : S_SMMOV;
      S_SMMOV:  if (done) state_nxt = S_TU;
      S_FIN:    state_nxt = u_one_r ? S_FSUB : S_FCOPY;
      S_FCOPY:  if (done) state_nxt = S_FSUB;
      S_FSUB:   if (done) state_nxt = flags.carry ? S_OUTRD : S_FMOV;
      S_FMOV:   if (done) state_nxt = S_OUTRD;
      S_OUTRD:  state_nxt = S_OUTLD;
      S_OUTLD:  state_nxt = S_OUTHOLD;
      S_OUTHOLD: if (out_ready) state_nxt = out_last_r ? S_CLRA : S_OUTRD;
      default:  state_nxt = S_CLRA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLRA;
      issued_r    <= 1'b0;
      lc_r        <= '0;
      long_r      <= 1'b0;
      mlsb_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        issued_r <= 1'b0;
      end else if (cmd.start) begin
        issued_r <= 1'b1;
      end
      case (state_r)
        S_CLRM: begin
          if (done) begin
            lc_r   <= '0;
            long_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mod_hold_r <= in_modulus_limb;
            final_r    <= in_final_limb;
          end
        end
        S_LDM: begin
          if (room) begin
            lc_r <= lc_r + 1'b1;
            if (lc_r == '0) begin
              mlsb_r <= mod_hold_r[0];
            end
          end else begin
            long_r <= 1'b1;
          end
        end
        S_CHECK: begin
          bitcnt_r <= BITS;
          k_r      <= '0;
          if (long_r) begin
            status_r <= ST_LONG;
          end else if (!mlsb_r) begin
            status_r <= ST_EVEN;
          end else begin
            status_r <= ST_OK;
          end
        end
        S_R2:   if (done) out_bit_r <= flags.carry;
        S_RDEC: bitcnt_r <= bitcnt_r - 1'b1;
        S_TU: begin
          if (done) begin
            u_one_r  <= flags.one;
            u_zero_r <= flags.zero;
          end
        end
        S_TV: begin
          if (done && !(u_one_r || flags.one) && (u_zero_r || flags.zero)) begin
            status_r <= ST_NOINV;
          end
        end
        S_SHU: which_r <= 1'b0;
        S_SHV: which_r <= 1'b1;
        S_CMP: if (done) which_r <= flags.carry;
        S_OUTLD: begin
          out_valid_r <= 1'b1;
          out_limb_r  <= (status_r == ST_OK) ? ext_rdata : '0;
          out_last_r  <= (k_r == TOP_IDX);
        end
        S_OUTHOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (!out_last_r) begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_limb = out_limb_r;
  assign out_status      = status_r;
  assign out_last_result = out_last_r;

endmodule

@@ hw/rtl/binary_modular_inverse_unit.sv @@
// Binary modular inverse unit, top level.
// Input channel (in_valid/in_ready): one beat per limb pair, operand and
// modulus, low limb first; in_final_limb marks the last beat and starts
// the inversion. Beats beyond LIMBS are dropped and give status 3.
// Output channel (out_valid/out_ready): LIMBS beats, low limb first, each
// with the job status; out_last_result flags the top limb. Non-zero
// status gives zero limbs.
// in_ready drops after each load beat while its modulus limb is
// written. All work runs on vectors in one limb memory through a
// limb-serial engine; the reduction runs 3 to 4 ops per operand bit
// (64*LIMBS bits), the Euclid loop 5 to 7 ops per halving step and 8 to
// 10 ops per subtraction step, so the job time is data dependent. One
// job is in flight at a time: in_ready is low from the final beat until
// the last result beat is taken and the stores are cleared again.
// out_valid drops between result beats.
// A stalled receiver simply holds the current result beat.
// After reset the operand and modulus stores are cleared by a pass
// during which in_ready stays low.
module binary_modular_inverse_unit
  import bmi_pkg::*;
#(
  parameter int LIMBS = LIMBS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LIMB_W-1:0] in_operand_limb,
  input  logic [LIMB_W-1:0] in_modulus_limb,
  input  logic              in_final_limb,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LIMB_W-1:0] out_result_limb,
  output logic [1:0]        out_status,
  output logic              out_last_result
);

  localparam int LW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int AW = VEC_W + LW;

  op_cmd_t           cmd;
  op_flags_t         flags;
  logic              ext_we;
  logic [AW-1:0]     ext_waddr;
  logic [LIMB_W-1:0] ext_wdata;
  logic [AW-1:0]     ext_raddr;
  logic [LIMB_W-1:0] ext_rdata;

  bmi_seq #(.LIMBS(LIMBS), .LW(LW), .AW(AW)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operand_limb (in_operand_limb),
    .in_modulus_limb (in_modulus_limb),
    .in_final_limb   (in_final_limb),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_limb (out_result_limb),
    .out_status      (out_status),
    .out_last_result (out_last_result),
    .cmd             (cmd),
    .flags           (flags),
    .ext_we          (ext_we),
    .ext_waddr       (ext_waddr),
    .ext_wdata       (ext_wdata),
    .ext_raddr       (ext_raddr),
    .ext_rdata       (ext_rdata)
  );

  bmi_alu #(.LIMBS(LIMBS), .LW(LW), .AW(AW)) u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .flags     (flags),
    .ext_we    (ext_we),
    .ext_waddr (ext_waddr),
    .ext_wdata (ext_wdata),
    .ext_raddr (ext_raddr),
    .ext_rdata (ext_rdata)
  );

endmodule
